// File: rtl/rbst_pkg.sv
// Shared types, constants and arithmetic helpers for the ray-box slab test.
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIR_W     = 21;
    localparam int NAXES     = 3;
    localparam int NLANES    = 2 * NAXES;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int NUM_W     = DIFF_W + FRAC_BITS;
    localparam int BPS       = 4;
    localparam int NSTG      = (NUM_W + BPS - 1) / BPS;
    localparam int QW        = NSTG * BPS;
    localparam int IN_W      = 9 * 32 + 64 + 64;
    localparam int OUT_W     = 8;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [QW-1:0] SAT_POS = (QW'(1) << (COORD_W - 1)) - QW'(1);
    localparam logic [QW-1:0] SAT_NEG = QW'(1) << (COORD_W - 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [DIFF_W-1:0] mag;
        logic              neg;
    } lane_t;

    typedef struct packed {
        logic [DIR_W-1:0] dmag;
        logic             dzero;
        logic             zok;
    } axis_t;

    typedef struct packed {
        lane_t [NLANES-1:0] lane;
        axis_t [NAXES-1:0]  axis;
        coord_t             lo;
        coord_t             hi;
    } item_t;

    typedef struct packed {
        logic [QW-1:0]    nq;
        logic [DIR_W-1:0] rem;
        logic             neg;
    } div_t;

    typedef struct packed {
        div_t  [NLANES-1:0] dv;
        axis_t [NAXES-1:0]  axis;
        coord_t             lo;
        coord_t             hi;
    } pipe_t;

    function automatic div_t div_step(div_t s, logic [DIR_W-1:0] d);
        div_t        r;
        logic [DIR_W:0] r2;
        logic        qb;
        r = s;
        for (int i = 0; i < BPS; i++)
        begin
            r2 = {r.rem, r.nq[QW-1]};
            qb = (r2 >= {1'b0, d});
            if (qb)
            begin
                r2 = r2 - {1'b0, d};
            end
            r.rem = r2[DIR_W-1:0];
            r.nq  = {r.nq[QW-2:0], qb};
        end
        return r;
    endfunction

    function automatic coord_t sat_quot(div_t s);
        coord_t v;
        if (s.neg)
        begin
            if (s.nq > SAT_NEG)
            begin
                v = coord_t'(SAT_NEG[COORD_W-1:0]);
            end
            else
            begin
                v = -coord_t'(s.nq[COORD_W-1:0]);
            end
        end
        else
        begin
            if (s.nq > SAT_POS)
            begin
                v = coord_t'(SAT_POS[COORD_W-1:0]);
            end
            else
            begin
                v = coord_t'(s.nq[COORD_W-1:0]);
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ray_box_slab_test_core.sv
// Top level of the ray versus axis-aligned box slab test.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one ray-box test per clock when nothing stalls and returns one hit flag per test,
// in order. The six slab quotients run in a restoring divider pipeline of 13 stages at four
// quotient bits each, followed by an ordering stage; the interval narrowing is computed
// straight into the output register. A four-entry queue between the input classification
// and the divider pipeline lets each side stall on its own; throughput is one transfer per
// cycle when neither side stalls.
module ray_box_slab_test_core
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output      logic                      s_axis_tready,
    // box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
    // origin_x, origin_y, origin_z, direction_xyz, param_range
    input  wire logic [rbst_pkg::IN_W-1:0] s_axis_tdata,
    output      logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // hit, then seven zero bits
    output      logic [rbst_pkg::OUT_W-1:0] m_axis_tdata
);
    import rbst_pkg::*;

    item_t front_item;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;
    logic  hit;

    rbst_front u_front
    (
        .tdata (s_axis_tdata),
        .item  (front_item)
    );

    rbst_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    rbst_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .hit       (hit)
    );

    assign m_axis_tdata = OUT_W'(hit);

endmodule
`default_nettype wire

// File: rtl/rbst_front.sv
// Front part: unpacks an input transfer and classifies each axis and slab bound.
`timescale 1ns / 1ps
`default_nettype none
module rbst_front
(
    input  wire logic [rbst_pkg::IN_W-1:0] tdata,
    output rbst_pkg::item_t                item
);
    import rbst_pkg::*;

    coord_t                   bnd [NLANES];
    coord_t                   org [NAXES];
    logic signed [DIR_W-1:0]  dir [NAXES];
    logic signed [DIFF_W-1:0] diff [NLANES];
    coord_t                   bmin;
    coord_t                   bmax;

    always_comb
    begin
        item = '0;
        for (int l = 0; l < NLANES; l++)
        begin
            bnd[l] = coord_t'(tdata[l*32 +: COORD_W]);
        end
        for (int a = 0; a < NAXES; a++)
        begin
            org[a] = coord_t'(tdata[(6 + a)*32 +: COORD_W]);
            dir[a] = tdata[288 + a*DIR_W +: DIR_W];
        end
        item.lo = coord_t'(tdata[352 +: COORD_W]);
        item.hi = coord_t'(tdata[384 +: COORD_W]);
        bmin = '0;
        bmax = '0;
        for (int l = 0; l < NLANES; l++)
        begin
            diff[l] = DIFF_W'(bnd[l]) - DIFF_W'(org[l / 2]);
            item.lane[l].mag = diff[l][DIFF_W-1] ? DIFF_W'(-diff[l]) : DIFF_W'(diff[l]);
            item.lane[l].neg = diff[l][DIFF_W-1] ^ dir[l / 2][DIR_W-1];
        end
        for (int a = 0; a < NAXES; a++)
        begin
            item.axis[a].dmag  = dir[a][DIR_W-1] ? DIR_W'(-dir[a]) : DIR_W'(dir[a]);
            item.axis[a].dzero = (dir[a] == '0);
            bmin = (bnd[2*a] < bnd[2*a+1]) ? bnd[2*a] : bnd[2*a+1];
            bmax = (bnd[2*a] < bnd[2*a+1]) ? bnd[2*a+1] : bnd[2*a];
            item.axis[a].zok = !item.axis[a].dzero || (org[a] >= bmin && org[a] <= bmax);
        end
    end

endmodule
`default_nettype wire

// File: rtl/rbst_queue.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module rbst_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire rbst_pkg::item_t in_item,
    output      logic            out_valid,
    input  wire logic            out_ready,
    output      rbst_pkg::item_t out_item
);
    import rbst_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (QPTR_W + 1)'(QDEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("queue output dropped while stalled");
`endif

endmodule
`default_nettype wire

// File: rtl/rbst_back.sv
// Back part: pipelined slab divisions, saturation, interval narrowing and output register.
`timescale 1ns / 1ps
`default_nettype none
module rbst_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire rbst_pkg::item_t in_item,
    output      logic            out_valid,
    input  wire logic            out_ready,
    output      logic            hit
);
    import rbst_pkg::*;

    localparam int TOP = NSTG + 2;

    pipe_t             p_reg [NSTG + 1];
    pipe_t             p0_next;
    pipe_t             stg_next [NSTG + 1];
    logic [TOP:0]      vld_reg;
    logic              adv;
    coord_t            tn_reg [NAXES];
    coord_t            tf_reg [NAXES];
    coord_t            tn_next [NAXES];
    coord_t            tf_next [NAXES];
    axis_t [NAXES-1:0] ax_reg;
    coord_t            lo_reg;
    coord_t            hi_reg;
    coord_t            t0;
    coord_t            t1;
    coord_t            lo_n;
    coord_t            hi_n;
    logic              ok;
    logic              hit_reg;
    logic              hit_next;

    assign adv       = !vld_reg[TOP] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[TOP];
    assign hit       = hit_reg;

    always_comb
    begin
        p0_next      = '0;
        p0_next.axis = in_item.axis;
        p0_next.lo   = in_item.lo;
        p0_next.hi   = in_item.hi;
        for (int l = 0; l < NLANES; l++)
        begin
            p0_next.dv[l].nq  = QW'({in_item.lane[l].mag, {FRAC_BITS{1'b0}}});
            p0_next.dv[l].rem = '0;
            p0_next.dv[l].neg = in_item.lane[l].neg;
        end
    end

    always_comb
    begin
        stg_next[0] = p0_next;
        for (int k = 1; k <= NSTG; k++)
        begin
            stg_next[k] = p_reg[k-1];
            for (int l = 0; l < NLANES; l++)
            begin
                stg_next[k].dv[l] = div_step(p_reg[k-1].dv[l], p_reg[k-1].axis[l / 2].dmag);
            end
        end
    end

    always_comb
    begin
        t0 = '0;
        t1 = '0;
        for (int a = 0; a < NAXES; a++)
        begin
            t0 = sat_quot(p_reg[NSTG].dv[2*a]);
            t1 = sat_quot(p_reg[NSTG].dv[2*a+1]);
            tn_next[a] = (t0 < t1) ? t0 : t1;
            tf_next[a] = (t0 < t1) ? t1 : t0;
        end
    end

    always_comb
    begin
        lo_n = lo_reg;
        hi_n = hi_reg;
        ok   = 1'b1;
        for (int a = 0; a < NAXES; a++)
        begin
            if (!ax_reg[a].zok)
            begin
                ok = 1'b0;
            end
            if (!ax_reg[a].dzero)
            begin
                if (tn_reg[a] > lo_n)
                begin
                    lo_n = tn_reg[a];
                end
                if (tf_reg[a] < hi_n)
                begin
                    hi_n = tf_reg[a];
                end
            end
        end
        hit_next = ok && (hi_n > lo_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOP-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                p_reg[k] <= stg_next[k];
            end
            for (int a = 0; a < NAXES; a++)
            begin
                tn_reg[a] <= tn_next[a];
                tf_reg[a] <= tf_next[a];
            end
            ax_reg  <= p_reg[NSTG].axis;
            lo_reg  <= p_reg[NSTG].lo;
            hi_reg  <= p_reg[NSTG].hi;
            hit_reg <= hit_next;
        end
    end

`ifndef SYNTH
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[TOP-1] |=> vld_reg[TOP])
        else $error("item lost before output register");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("output changed while stalled");
`endif

endmodule
`default_nettype wire
